>>> rtl/itt_pkg.sv
package itt_pkg;

  // Request codes
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_MISSING = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_EMPTY   = 2'd3;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_MISSING_CODE   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MISSING_MARGIN = 1'b1;

  // Register reset values: -999.0 in Q16.16 and the smallest margin
  localparam logic [31:0] MISSING_CODE_RST   = 32'hFC190000;
  localparam logic [15:0] MISSING_MARGIN_RST = 16'd1;

  // Fraction divider: one quotient bit per step
  localparam int unsigned FracW     = 16;
  localparam int unsigned DivCntW   = 4;
  localparam logic [FracW-1:0] FRAC_MAX = '1;

  typedef struct packed {
    logic signed [31:0] pt_time;
    logic signed [31:0] pt_value;
  } point_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_APPEND,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_SINGLE,
    ST_LO,
    ST_HI,
    ST_CHECK,
    ST_NUMER,
    ST_DIFF,
    ST_ABSN,
    ST_ABSD,
    ST_DIVCMP,
    ST_DIV,
    ST_MUL,
    ST_FIN,
    ST_DONE
  } state_e;

endpackage

>>> rtl/itt_if.sv
interface itt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] sample_time;
  logic signed [31:0] sample_value;

  modport source (output valid, req_type, sample_time, sample_value, input ready);
  modport sink   (input valid, req_type, sample_time, sample_value, output ready);
endinterface

interface itt_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         result_status;

  modport source (output valid, result_value, result_status, input ready);
  modport sink   (input valid, result_value, result_status, output ready);
endinterface

interface itt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [itt_pkg::CfgIdxW-1:0]  reg_index;
  logic [31:0]                  wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

>>> rtl/itt_store.sv
module itt_store #(
  parameter int unsigned Depth = 256
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(Depth)-1:0]       waddr_i,
  input  itt_pkg::point_t                wdata_i,
  input  logic [$clog2(Depth)-1:0]       raddr_i,
  output itt_pkg::point_t                rdata_o
);
  import itt_pkg::*;

  logic [31:0] time_mem  [Depth];
  logic [31:0] value_mem [Depth];
  logic [31:0] time_rd_q;
  logic [31:0] value_rd_q;

  // Write one point, read one point a cycle with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_mem[waddr_i] <= wdata_i.pt_time;
    end
    time_rd_q <= time_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      value_mem[waddr_i] <= wdata_i.pt_value;
    end
    value_rd_q <= value_mem[raddr_i];
  end

  assign rdata_o.pt_time  = time_rd_q;
  assign rdata_o.pt_value = value_rd_q;

endmodule

>>> rtl/interp_time_table.sv
// Piecewise linear interpolation over a table of (time, value) points, Q16.16.
// Request channel (req_i): req_type 0 appends (sample_time, sample_value),
// 1 queries the value at sample_time, 2 clears the table. Every request word
// yields exactly one response word on rsp_o (result_value, result_status).
// Configuration (cfg_i, always ready): index 0 sets the missing code, index 1
// the missing margin; write only while no request is in flight.
// Requests are handled one at a time; req_i is ready only while idle, so each
// request passes back through idle before the next is taken. Append goes
// through the append state and then the done state, which loads the response
// register; clear, unknown requests and queries on an empty table go straight
// to the done state. For a query, the bracket scan reads one stored time per
// cycle from the single read port of the point memory, then one shared 35-bit
// adder does the differences, absolute values and a 16-step restoring division
// for the Q0.16 fraction, followed by a multiply and a final add.
// The response sits in an output register; the block takes the next request
// while it waits, but does not finish another one until rsp_o.ready drains it.
// Reset empties the table (the point count goes to zero; memory contents
// are not cleared) and restores the configuration registers to their defaults.
module interp_time_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itt_req_if.sink    req_i,
  itt_rsp_if.source  rsp_o,
  itt_cfg_if.sink    cfg_i
);
  import itt_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);

  state_e               state_q, state_d;
  logic signed [31:0]   t_q, t_d;
  logic signed [31:0]   sv_q, sv_d;
  logic signed [33:0]   thr_q, thr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [AddrW-1:0]     lo_q, lo_d;
  logic signed [31:0]   tl_q, tl_d, th_q, th_d, vl_q, vl_d, vh_q, vh_d;
  logic signed [32:0]   den_q, den_d, num_q, num_d, diff_q, diff_d;
  logic [32:0]          an_q, an_d, ad_q, ad_d, rem_q, rem_d;
  logic [FracW-1:0]     frac_q, frac_d;
  logic [DivCntW-1:0]   dcnt_q, dcnt_d;
  logic signed [49:0]   prod_q, prod_d;
  logic signed [31:0]   res_q, res_d;
  logic [1:0]           stat_q, stat_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [31:0]   out_value_q, out_value_d;
  logic [1:0]           out_stat_q, out_stat_d;
  logic signed [31:0]   mc_q;
  logic [15:0]          margin_q;

  // Point memory interface
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  point_t               mem_wdata, mem_rdata;

  // Shared adder
  logic signed [34:0]   alu_a, alu_b, alu_res;
  logic                 alu_sub;

  // Helpers
  logic [33:0]          rem2;
  logic                 vl_miss, vh_miss, rd_miss;

  itt_store #(
    .Depth (TABLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign rem2    = {rem_q, 1'b0};

  // Compare against missing_code + missing_margin
  assign vl_miss = $signed({{2{vl_q[31]}}, vl_q}) < thr_q;
  assign vh_miss = $signed({{2{vh_q[31]}}, vh_q}) < thr_q;
  assign rd_miss = $signed({{2{mem_rdata.pt_value[31]}}, mem_rdata.pt_value}) < thr_q;

  assign mem_wdata.pt_time  = t_q;
  assign mem_wdata.pt_value = sv_q;
  assign mem_waddr          = AddrW'(cnt_q);

  // Drive the handshakes
  assign req_i.ready         = (state_q == ST_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_value  = out_value_q;
  assign rsp_o.result_status = out_stat_q;

  // Select shared adder operands
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_q)
      ST_CHECK: begin
        alu_a = {{3{th_q[31]}}, th_q};
        alu_b = {{3{tl_q[31]}}, tl_q};
      end
      ST_NUMER: begin
        alu_a = {{3{t_q[31]}}, t_q};
        alu_b = {{3{tl_q[31]}}, tl_q};
      end
      ST_DIFF: begin
        alu_a = {{3{vh_q[31]}}, vh_q};
        alu_b = {{3{vl_q[31]}}, vl_q};
      end
      ST_ABSN: begin
        alu_b = {{2{num_q[32]}}, num_q};
      end
      ST_ABSD: begin
        alu_b = {{2{den_q[32]}}, den_q};
      end
      ST_DIVCMP: begin
        alu_a = {2'b00, an_q};
        alu_b = {2'b00, ad_q};
      end
      ST_DIV: begin
        alu_a = {1'b0, rem2};
        alu_b = {2'b00, ad_q};
      end
      ST_FIN: begin
        alu_a   = {{3{vl_q[31]}}, vl_q};
        alu_b   = {prod_q[49], prod_q[49:16]};
        alu_sub = 1'b0;
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
  end

  // Sequence one request word at a time
  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    sv_d        = sv_q;
    thr_d       = thr_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    tl_d        = tl_q;
    th_d        = th_q;
    vl_d        = vl_q;
    vh_d        = vh_q;
    den_d       = den_q;
    num_d       = num_q;
    diff_d      = diff_q;
    an_d        = an_q;
    ad_d        = ad_q;
    rem_d       = rem_q;
    frac_d      = frac_q;
    dcnt_d      = dcnt_q;
    prod_d      = prod_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_stat_d  = out_stat_q;
    mem_we      = 1'b0;
    mem_raddr   = '0;

    // Drop the response once taken
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          t_d    = req_i.sample_time;
          sv_d   = req_i.sample_value;
          thr_d  = {{2{mc_q[31]}}, mc_q} + $signed({18'd0, margin_q});
          res_d  = '0;
          stat_d = STAT_OK;
          case (req_i.req_type)
            REQ_APPEND: begin
              state_d = ST_APPEND;
            end
            REQ_QUERY: begin
              if (cnt_q == '0) begin
                res_d   = mc_q;
                stat_d  = STAT_EMPTY;
                state_d = ST_DONE;
              end else begin
                state_d = ST_FIRST;
              end
            end
            REQ_CLEAR: begin
              cnt_d   = '0;
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_APPEND: begin
        if (cnt_q == CntW'(TABLE_DEPTH)) begin
          stat_d = STAT_FULL;
        end else begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
        end
        state_d = ST_DONE;
      end

      // Check against the first stored time, fetch the last
      ST_FIRST: begin
        mem_raddr = AddrW'(cnt_q - CntW'(1));
        if (t_q < mem_rdata.pt_time) begin
          res_d   = mc_q;
          stat_d  = STAT_MISSING;
          state_d = ST_DONE;
        end else begin
          state_d = ST_LAST;
        end
      end

      ST_LAST: begin
        lo_d = '0;
        if (t_q > mem_rdata.pt_time) begin
          res_d   = mc_q;
          stat_d  = STAT_MISSING;
          state_d = ST_DONE;
        end else if (cnt_q > CntW'(1)) begin
          mem_raddr = AddrW'(1);
          state_d   = ST_SCAN;
        end else begin
          state_d = ST_SINGLE;
        end
      end

      // Advance the lower index while the time lies past the next entry
      ST_SCAN: begin
        if (t_q > mem_rdata.pt_time) begin
          lo_d = lo_q + AddrW'(1);
          if ((CntW'(lo_q) + CntW'(2)) < cnt_q) begin
            mem_raddr = lo_q + AddrW'(2);
          end else begin
            mem_raddr = lo_q + AddrW'(1);
            state_d   = ST_SINGLE;
          end
        end else begin
          mem_raddr = lo_q;
          state_d   = ST_LO;
        end
      end

      // No upper neighbor: return the lower value, or the missing code if it is missing
      ST_SINGLE: begin
        if (rd_miss) begin
          res_d  = mc_q;
          stat_d = STAT_MISSING;
        end else begin
          res_d = mem_rdata.pt_value;
        end
        state_d = ST_DONE;
      end

      ST_LO: begin
        tl_d      = mem_rdata.pt_time;
        vl_d      = mem_rdata.pt_value;
        mem_raddr = lo_q + AddrW'(1);
        state_d   = ST_HI;
      end

      ST_HI: begin
        th_d    = mem_rdata.pt_time;
        vh_d    = mem_rdata.pt_value;
        state_d = ST_CHECK;
      end

      ST_CHECK: begin
        den_d = alu_res[32:0];
        if (vl_miss || vh_miss) begin
          res_d   = mc_q;
          stat_d  = STAT_MISSING;
          state_d = ST_DONE;
        end else if (tl_q == th_q) begin
          res_d   = vl_q;
          state_d = ST_DONE;
        end else if (t_q == th_q) begin
          res_d   = vh_q;
          state_d = ST_DONE;
        end else begin
          state_d = ST_NUMER;
        end
      end

      ST_NUMER: begin
        num_d   = alu_res[32:0];
        state_d = ST_DIFF;
      end

      ST_DIFF: begin
        diff_d  = alu_res[32:0];
        state_d = ST_ABSN;
      end

      ST_ABSN: begin
        an_d    = num_q[32] ? alu_res[32:0] : num_q;
        state_d = ST_ABSD;
      end

      ST_ABSD: begin
        ad_d    = den_q[32] ? alu_res[32:0] : den_q;
        state_d = ST_DIVCMP;
      end

      // Opposite signs give zero; a quotient of one or more saturates
      ST_DIVCMP: begin
        rem_d  = an_q;
        dcnt_d = '0;
        if (num_q[32] != den_q[32]) begin
          frac_d  = '0;
          state_d = ST_MUL;
        end else if (!alu_res[34]) begin
          frac_d  = FRAC_MAX;
          state_d = ST_MUL;
        end else begin
          state_d = ST_DIV;
        end
      end

      // Restoring division, one quotient bit per cycle
      ST_DIV: begin
        if (!alu_res[34]) begin
          rem_d  = alu_res[32:0];
          frac_d = {frac_q[FracW-2:0], 1'b1};
        end else begin
          rem_d  = rem2[32:0];
          frac_d = {frac_q[FracW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + DivCntW'(1);
        if (dcnt_q == DivCntW'(FracW - 1)) begin
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_d  = diff_q * $signed({1'b0, frac_q});
        state_d = ST_FIN;
      end

      ST_FIN: begin
        res_d   = alu_res[31:0];
        state_d = ST_DONE;
      end

      // Hand the word to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = res_q;
          out_stat_d  = stat_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q     <= MISSING_CODE_RST;
      margin_q <= MISSING_MARGIN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        CFG_MISSING_CODE: begin
          mc_q <= cfg_i.wr_data;
        end
        CFG_MISSING_MARGIN: begin
          margin_q <= cfg_i.wr_data[15:0];
        end
        default: begin
          mc_q <= mc_q;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    t_q         <= t_d;
    sv_q        <= sv_d;
    thr_q       <= thr_d;
    lo_q        <= lo_d;
    tl_q        <= tl_d;
    th_q        <= th_d;
    vl_q        <= vl_d;
    vh_q        <= vh_d;
    den_q       <= den_d;
    num_q       <= num_d;
    diff_q      <= diff_d;
    an_q        <= an_d;
    ad_q        <= ad_d;
    rem_q       <= rem_d;
    frac_q      <= frac_d;
    dcnt_q      <= dcnt_d;
    prod_q      <= prod_d;
    res_q       <= res_d;
    stat_q      <= stat_d;
    out_value_q <= out_value_d;
    out_stat_q  <= out_stat_d;
  end

endmodule
